### src/rx_frame_checker_crc16_macros.svh
// Assertion macros shared by the frame checker RTL.
`ifndef RX_FRAME_CHECKER_CRC16_MACROS_SVH
`define RX_FRAME_CHECKER_CRC16_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define RFC16_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("rfc16 assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define RFC16_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rfc16 implication failed");

// Check that a condition implies a consequence in the next cycle.
`define RFC16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rfc16 next-cycle check failed");

`else

`define RFC16_ASSERT(label, clk, rst_n, prop)
`define RFC16_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RFC16_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/rfc16_pkg.sv
package rfc16_pkg;

	localparam int          FRAME_LEN_DEF = 8;
	localparam int          POS_W         = 6;
	localparam int          CRC_W         = 16;

	localparam logic [7:0]  HEAD_BYTE     = 8'hAA;
	localparam logic [15:0] CRC_POLY      = 16'h1021;
	localparam logic [7:0]  ADDR_RESET    = 8'h01;

	localparam logic [1:0]  ST_OK         = 2'd0;
	localparam logic [1:0]  ST_BAD_HEAD   = 2'd1;
	localparam logic [1:0]  ST_BAD_ADDR   = 2'd2;
	localparam logic [1:0]  ST_BAD_CRC    = 2'd3;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] command;
		logic [7:0] first_data;
		logic [7:0] second_data;
	} out_item_t;

	// Control of the work stage, from the top level to the frame tracker.
	typedef struct packed {
		logic valid;
		logic advance;
	} stage_ctrl_t;

endpackage

### src/rfc16_crc_step.sv
module rfc16_crc_step
	import rfc16_pkg::*;
(
	input  logic [CRC_W-1:0] crc,
	input  logic [7:0]       data,
	output logic [CRC_W-1:0] crc_next
);

	// CRC-16, poly 0x1021, MSB first, one byte per pass.
	always_comb begin
		logic [CRC_W-1:0] c;
		c = crc ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		crc_next = c;
	end

endmodule

### src/rfc16_out_reg.sv
module rfc16_out_reg
	import rfc16_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  out_item_t load_data,
	input  logic      out_stall,
	output logic      free,
	output logic      out_valid,
	output out_item_t out_data
);

	logic      valid_q;
	out_item_t data_q;

	// Slot is free when empty or being drained this cycle.
	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

### src/rfc16_frame_track.sv
`include "rx_frame_checker_crc16_macros.svh"

module rfc16_frame_track
	import rfc16_pkg::*;
#(
	parameter int FRAME_LEN = FRAME_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  stage_ctrl_t ctrl,
	input  in_item_t    item,
	input  logic [7:0]  local_address,
	output logic        produce,
	output out_item_t   result
);

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
	localparam logic [POS_W-1:0] CRC_HI_POS = POS_W'(FRAME_LEN - 2);

	logic [POS_W-1:0] pos_q;
	logic [CRC_W-1:0] crc_q;
	logic [1:0]       err_q;
	logic [7:0]       cmd_q;
	logic [7:0]       data0_q;
	logic [7:0]       data1_q;
	logic [7:0]       crc_hi_q;

	logic [POS_W-1:0] pos_eff;
	logic [POS_W-1:0] pos_next;
	logic [CRC_W-1:0] crc_seed;
	logic [CRC_W-1:0] crc_upd;
	logic [1:0]       err_next;

	// Start mark or out-of-range position restarts at byte 0.
	assign pos_eff  = (item.frame_start || pos_q > LAST_POS) ? '0 : pos_q;
	assign pos_next = (pos_eff == LAST_POS) ? '0 : pos_eff + POS_W'(1);
	assign produce  = ctrl.valid && (pos_eff == LAST_POS);
	assign crc_seed = (pos_eff == '0) ? '0 : crc_q;

	rfc16_crc_step u_crc (
		.crc      (crc_seed),
		.data     (item.rx_byte),
		.crc_next (crc_upd)
	);

	always_comb begin
		err_next = err_q;
		if (pos_eff == '0) begin
			err_next = (item.rx_byte != HEAD_BYTE) ? ST_BAD_HEAD : ST_OK;
		end else if (pos_eff == POS_W'(1)) begin
			if (err_q == ST_OK && item.rx_byte != local_address) begin
				err_next = ST_BAD_ADDR;
			end
		end
	end

	always_comb begin
		result.status = err_q;
		if (err_q == ST_OK && {crc_hi_q, item.rx_byte} != crc_q) begin
			result.status = ST_BAD_CRC;
		end
		result.command     = cmd_q;
		result.first_data  = data0_q;
		result.second_data = data1_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (ctrl.advance) begin
			pos_q <= pos_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			err_q <= err_next;
			if (pos_eff < CRC_HI_POS) begin
				crc_q <= crc_upd;
			end
			if (pos_eff == CRC_HI_POS) begin
				crc_hi_q <= item.rx_byte;
			end
			if (pos_eff == POS_W'(2)) begin
				cmd_q <= item.rx_byte;
			end
			if (pos_eff == POS_W'(3)) begin
				data0_q <= item.rx_byte;
			end
			if (pos_eff == POS_W'(4)) begin
				data1_q <= item.rx_byte;
			end
		end
	end

	`RFC16_ASSERT(a_pos_in_frame, clk, arst_n, pos_q <= LAST_POS)
	`RFC16_ASSERT_NEXT(a_start_to_one, clk, arst_n, ctrl.advance && item.frame_start, pos_q == POS_W'(1))
	`RFC16_ASSERT_IMPL(a_result_on_last, clk, arst_n, produce, !item.frame_start && pos_q == LAST_POS)

endmodule

### src/rx_frame_checker_crc16.sv
// Channel  Signals                         Direction  Moves
// in       in_valid / in_stall / in_data   receive    one frame byte and start mark
// out      out_valid / out_stall / out_data send      one check result per frame
// cfg      cfg_we / cfg_wdata              receive    local address, no read-back
//
// One item per cycle sustained unless a stalled output holds the input; an accepted byte sits in the
// input register for the work stage, and its result, if any, is loaded into the output register when
// that byte advances. Rate is set by the bytewise CRC network between the input and result registers.
// Reset is asynchronous, active low; the local address comes back as 0x01.
// A stalled output only holds the input side when the waiting byte ends a frame.
`include "rx_frame_checker_crc16_macros.svh"

module rx_frame_checker_crc16
	import rfc16_pkg::*;
#(
	parameter int FRAME_LEN = FRAME_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic [7:0] cfg_wdata
);

	// Input register: holds the accepted item for the work stage.
	logic        valid_s1;
	in_item_t    item_s1;
	logic [7:0]  local_address_q;

	logic        produce;
	logic        out_free;
	logic        advance;
	logic        accept;
	stage_ctrl_t ctrl;
	out_item_t   result;

	// Advance the stage unless its result has nowhere to go.
	assign advance  = valid_s1 && (!produce || out_free);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign ctrl.valid   = valid_s1;
	assign ctrl.advance = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	// Configuration register: the user must write it only while the block is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q <= ADDR_RESET;
		end else if (cfg_we) begin
			local_address_q <= cfg_wdata;
		end
	end

	rfc16_frame_track #(
		.FRAME_LEN (FRAME_LEN)
	) u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.item          (item_s1),
		.local_address (local_address_q),
		.produce       (produce),
		.result        (result)
	);

	// Result register: load the check result when the last byte advances.
	rfc16_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (produce && advance),
		.load_data (result),
		.out_stall (out_stall),
		.free      (out_free),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	`RFC16_ASSERT_IMPL(a_no_overwrite, clk, arst_n, out_valid && out_stall && produce, in_stall)
	`RFC16_ASSERT_IMPL(a_stall_only_full, clk, arst_n, in_stall, produce && out_valid && out_stall)
	`RFC16_ASSERT_NEXT(a_last_loads, clk, arst_n, produce && advance, out_valid)

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import rfc16_pkg::*;

	localparam int FRAME_LEN = FRAME_LEN_DEF;

	// Defects that the frame builder can put into a frame; any mix is allowed.
	localparam logic [2:0] FLAW_NONE = 3'b000;
	localparam logic [2:0] FLAW_HEAD = 3'b001;
	localparam logic [2:0] FLAW_ADDR = 3'b010;
	localparam logic [2:0] FLAW_CRC  = 3'b100;

	// Settle time after the last result: time for the work stage and the result register,
	// plus margin for bytes that end no frame.
	localparam int SETTLE_CYCLES = 4;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic      cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;

	rx_frame_checker_crc16 #(
		.FRAME_LEN(FRAME_LEN)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Bytes waiting to be driven, and frame results waiting to come out.
	in_item_t  pending_bytes[$];
	out_item_t frame_results_q[$];

	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned bytes_queued = 0;
	int unsigned mismatch_count = 0;
	logic        byte_taken = 1'b0;

	// Shadow of the frame tracker inside the block.
	logic [5:0]  frame_pos;
	logic [15:0] crc_acc;
	logic [1:0]  first_error;
	logic [7:0]  cmd_seen;
	logic [15:0] payload_seen;
	logic [7:0]  crc_hi_seen;
	logic [7:0]  addr_setting;

	// CRC-16/XMODEM over one byte, MSB first.
	function automatic logic [15:0] crc16_xmodem_byte(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction

	// Advance the frame shadow by one accepted byte; queue a result on the last byte.
	task automatic track_frame_byte(input in_item_t it);
		logic [5:0] p;
		logic [15:0] rx_crc;
		out_item_t r;
		if (it.frame_start || frame_pos >= FRAME_LEN)
			frame_pos = '0;
		p = frame_pos;
		if (p == 0) begin
			crc_acc = '0;
			first_error = (it.rx_byte != HEAD_BYTE) ? ST_BAD_HEAD : ST_OK;
		end else if (p == 1) begin
			if (first_error == ST_OK && it.rx_byte != addr_setting)
				first_error = ST_BAD_ADDR;
		end else if (p == 2) begin
			cmd_seen = it.rx_byte;
		end else if (p == 3) begin
			payload_seen[15:8] = it.rx_byte;
		end else if (p == 4) begin
			payload_seen[7:0] = it.rx_byte;
		end

		if (p < FRAME_LEN - 2) begin
			crc_acc = crc16_xmodem_byte(crc_acc, it.rx_byte);
		end else if (p == FRAME_LEN - 2) begin
			crc_hi_seen = it.rx_byte;
		end else begin
			// CRC mismatch only shows when no earlier error was recorded.
			rx_crc = {crc_hi_seen, it.rx_byte};
			r.status = first_error;
			if (first_error == ST_OK && rx_crc != crc_acc)
				r.status = ST_BAD_CRC;
			r.command = cmd_seen;
			r.first_data = payload_seen[15:8];
			r.second_data = payload_seen[7:0];
			frame_results_q.push_back(r);
		end

		if (p + 1 >= FRAME_LEN)
			frame_pos = '0;
		else
			frame_pos = p + 1'b1;
	endtask

	// Build one frame and queue its first keep bytes. Bytes past the second
	// payload byte and before the CRC are random.
	task automatic queue_frame(input logic [2:0] flaw, input logic start_mark,
			input logic [7:0] addr, input logic [7:0] cmd, input logic [7:0] d1,
			input logic [7:0] d2, input int unsigned keep);
		logic [7:0] fb [FRAME_LEN];
		logic [15:0] crc;
		in_item_t it;
		fb[0] = HEAD_BYTE;
		if (flaw & FLAW_HEAD) begin
			fb[0] = 8'($urandom_range(255));
			if (fb[0] == HEAD_BYTE)
				fb[0] = ~fb[0];
		end
		fb[1] = (flaw & FLAW_ADDR) ? (addr ^ 8'($urandom_range(1, 255))) : addr;
		fb[2] = cmd;
		fb[3] = d1;
		fb[4] = d2;
		for (int i = 5; i < FRAME_LEN - 2; i++)
			fb[i] = 8'($urandom_range(255));
		crc = '0;
		for (int i = 0; i < FRAME_LEN - 2; i++)
			crc = crc16_xmodem_byte(crc, fb[i]);
		if (flaw & FLAW_CRC)
			crc = crc ^ 16'($urandom_range(1, 65535));
		fb[FRAME_LEN - 2] = crc[15:8];
		fb[FRAME_LEN - 1] = crc[7:0];
		for (int i = 0; i < FRAME_LEN && i < keep; i++) begin
			it.rx_byte = fb[i];
			it.frame_start = (i == 0) ? start_mark : 1'b0;
			pending_bytes.push_back(it);
			bytes_queued++;
		end
	endtask

	// Random bytes with a random start mark now and then.
	task automatic queue_noise(input int unsigned n);
		in_item_t it;
		for (int i = 0; i < n; i++) begin
			it.rx_byte = 8'($urandom_range(255));
			it.frame_start = ($urandom_range(99) < 20);
			pending_bytes.push_back(it);
			bytes_queued++;
		end
	endtask

	// Driver: present a new byte only once the current one is gone; hold it
	// otherwise. Valid never looks at stall.
	always @(negedge clk) begin
		if (!in_valid || byte_taken) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
				in_data <= pending_bytes.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Monitor: track accepted bytes, check accepted results, follow register writes.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			frame_pos = '0;
			crc_acc = '0;
			first_error = ST_OK;
			cmd_seen = '0;
			payload_seen = '0;
			crc_hi_seen = '0;
			addr_setting = ADDR_RESET;
			byte_taken <= 1'b0;
		end else begin
			byte_taken <= in_valid && !in_stall;
			if (cfg_we)
				addr_setting = cfg_wdata;
			// Check before tracking: a result never leaves in the cycle its byte goes in.
			if (out_valid && !out_stall) begin
				if (frame_results_q.size() == 0) begin
					$error("result with no frame pending: status %0d command %02h",
						out_data.status, out_data.command);
					mismatch_count++;
				end else begin
					want = frame_results_q.pop_front();
					if (out_data.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_data.status);
						mismatch_count++;
					end
					if (out_data.command !== want.command) begin
						$error("command: expected %02h, got %02h",
							want.command, out_data.command);
						mismatch_count++;
					end
					if (out_data.first_data !== want.first_data) begin
						$error("first_data: expected %02h, got %02h",
							want.first_data, out_data.first_data);
						mismatch_count++;
					end
					if (out_data.second_data !== want.second_data) begin
						$error("second_data: expected %02h, got %02h",
							want.second_data, out_data.second_data);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				track_frame_byte(in_data);
		end
	end

	// Wait until every byte is in, every result is out and the pipeline is empty.
	task automatic drain();
		while (pending_bytes.size() != 0 || in_valid || frame_results_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the local address while the block is idle.
	task automatic write_address(input logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [7:0] phase_addr [4];
		int unsigned gap_sel [4];
		int unsigned stall_sel [4];
		int unsigned phase_target;
		int unsigned pick;
		logic [2:0] flaw;
		logic aligned;

		phase_addr[0] = 8'h00;
		phase_addr[1] = 8'hFF;
		phase_addr[2] = 8'($urandom_range(255));
		phase_addr[3] = HEAD_BYTE;
		gap_sel[0] = 0;   stall_sel[0] = 0;
		gap_sel[1] = 63;  stall_sel[1] = 0;
		gap_sel[2] = 0;   stall_sel[2] = 63;
		gap_sel[3] = 25;  stall_sel[3] = 25;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: clean frame at payload extremes under the reset address,
		// a frame cut short by a new start mark, a wrong address that masks a
		// wrong CRC, and a frame with no start mark relying on the wrap.
		queue_frame(FLAW_NONE, 1'b1, ADDR_RESET, 8'hFF, 8'h00, 8'hFF, FRAME_LEN);
		queue_frame(FLAW_NONE, 1'b1, ADDR_RESET, 8'h5A, 8'hA5, 8'h3C, 3);
		queue_frame(FLAW_ADDR | FLAW_CRC, 1'b1, ADDR_RESET, 8'h01, 8'h80, 8'h7F,
			FRAME_LEN);
		queue_frame(FLAW_CRC, 1'b0, ADDR_RESET, 8'h00, 8'hFF, 8'h00, FRAME_LEN);
		drain();

		// Random: mostly well-formed frames with random content, some with
		// defects, plus cut frames and loose bytes to knock the framing off.
		for (int ph = 0; ph < 4; ph++) begin
			write_address(phase_addr[ph]);
			gap_pct = gap_sel[ph];
			stall_pct = stall_sel[ph];
			phase_target = bytes_queued + 330;
			aligned = 1'b1;
			while (bytes_queued < phase_target) begin
				pick = $urandom_range(99);
				if (pick < 80) begin
					flaw = ($urandom_range(99) < 65) ? FLAW_NONE : 3'($urandom_range(1, 7));
					queue_frame(flaw, aligned ? ($urandom_range(99) >= 20) : 1'b1,
						phase_addr[ph], 8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), FRAME_LEN);
					aligned = 1'b1;
				end else if (pick < 90) begin
					queue_frame(FLAW_NONE, 1'b1, phase_addr[ph], 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)),
						$urandom_range(1, FRAME_LEN - 1));
					aligned = 1'b0;
				end else begin
					queue_noise($urandom_range(1, 6));
					aligned = 1'b0;
				end
			end
			drain();
		end

		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Hard stop if the handshakes hang.
	initial begin
		#400000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
